/* sv/afc_pkg.sv */
// package: shared constants and types of the box frustum culling block
`timescale 1ns / 1ps
package afc_pkg;

  localparam int unsigned PLANE_COUNT = 6;
  localparam int unsigned AXIS_COUNT  = 3;

  localparam int unsigned NORM_W   = 12;
  localparam int unsigned OFFS_W   = 28;
  localparam int unsigned OFFS_LSB = 36;
  localparam int unsigned PLANE_W  = 64;
  localparam int unsigned HEIGHT_W = 9;

  localparam int unsigned CELL_XZ_W = 12;
  localparam int unsigned CELL_Y_W  = 8;
  localparam int unsigned IN_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 8;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SECT_HEIGHT  = 3'd6;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 9'd16;

  typedef enum logic [1:0] {
    CLS_OUTSIDE   = 2'd0,
    CLS_INTERSECT = 2'd1,
    CLS_INSIDE    = 2'd2
  } class_e;

endpackage

/* sv/aabb_frustum_cull_top.sv */
// Tests the box of each chunk section against six frustum planes. One item is
// taken per clock while s_axis_tready is high, through four registered stages:
// the first stage forms the box corners (one small multiply for y), the second
// multiplies each plane normal with the chosen corners (36 multipliers of 12 bits
// by the corner width), the third sums and takes the signs, the fourth classifies
// and holds the result. Every stage has its own valid bit and can fill while the
// output waits, so a stalled sink holds up the input only once all four are full.
// The user must write planes and section height (cfg_we_i/cfg_index_i/cfg_data_i)
// only while no item is in flight (not enforced); indexes past height are ignored.
`timescale 1ns / 1ps
module aabb_frustum_cull_top
  import afc_pkg::*;
#(
  parameter int unsigned CHUNK_SPAN = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [PLANE_W-1:0]    cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // cell_x, cell_y, cell_z
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // classification, visible, zero pad
);

  localparam int unsigned XW = 14 + $clog2(CHUNK_SPAN + 1);
  localparam int unsigned CW = (XW > 20) ? XW : 20;
  localparam int unsigned PW = NORM_W + CW;
  localparam int unsigned SW = PW + 2;
  localparam logic signed [CW-1:0] SPAN_S = CW'(CHUNK_SPAN);

  logic [PLANE_W-1:0]  plane_q [PLANE_COUNT];
  logic [HEIGHT_W-1:0] height_q;

  logic [3:0] v_q;
  logic       en1, en2, en3, en4;

  logic signed [CW-1:0] lo1_d [AXIS_COUNT];
  logic signed [CW-1:0] hi1_d [AXIS_COUNT];
  logic signed [CW-1:0] lo1_q [AXIS_COUNT];
  logic signed [CW-1:0] hi1_q [AXIS_COUNT];

  logic signed [PW-1:0] pp2_d [PLANE_COUNT][AXIS_COUNT];
  logic signed [PW-1:0] pn2_d [PLANE_COUNT][AXIS_COUNT];
  logic signed [PW-1:0] pp2_q [PLANE_COUNT][AXIS_COUNT];
  logic signed [PW-1:0] pn2_q [PLANE_COUNT][AXIS_COUNT];

  logic [PLANE_COUNT-1:0] pneg3_d, nneg3_d, pneg3_q, nneg3_q;

  class_e cls4_d, cls4_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        plane_q[i] <= '0;
      end
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_SECT_HEIGHT) begin
        height_q <= cfg_data_i[HEIGHT_W-1:0];
      end else if (32'(cfg_index_i) < PLANE_COUNT) begin
        plane_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  // stage enables
  assign en4 = !v_q[3] || m_axis_tready;
  assign en3 = !v_q[2] || en4;
  assign en2 = !v_q[1] || en3;
  assign en1 = !v_q[0] || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en1) v_q[0] <= s_axis_tvalid;
      if (en2) v_q[1] <= v_q[0];
      if (en3) v_q[2] <= v_q[1];
      if (en4) v_q[3] <= v_q[2];
    end
  end

  // stage 1: box corners
  always_comb begin
    logic signed [CW-1:0] cx, cy, cz, sh;
    cx = CW'($signed(s_axis_tdata[CELL_XZ_W-1:0]));
    cy = CW'($signed(s_axis_tdata[CELL_XZ_W+CELL_Y_W-1:CELL_XZ_W]));
    cz = CW'($signed(s_axis_tdata[IN_DATA_W-1:CELL_XZ_W+CELL_Y_W]));
    sh = $signed(CW'(height_q));
    lo1_d[0] = cx * SPAN_S;
    lo1_d[1] = cy * sh;
    lo1_d[2] = cz * SPAN_S;
    hi1_d[0] = lo1_d[0] + SPAN_S;
    hi1_d[1] = lo1_d[1] + sh;
    hi1_d[2] = lo1_d[2] + SPAN_S;
  end

  always_ff @(posedge clk_i) begin
    if (en1 && s_axis_tvalid) begin
      lo1_q <= lo1_d;
      hi1_q <= hi1_d;
    end
  end

  // stage 2: normal times p and n corners
  always_comb begin
    logic signed [NORM_W-1:0] nrm;
    logic signed [PW-1:0]     nx, pc, nc;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      for (int k = 0; k < AXIS_COUNT; k++) begin
        nrm = $signed(plane_q[i][k*NORM_W +: NORM_W]);
        nx  = PW'(nrm);
        if (!nrm[NORM_W-1] && (nrm != '0)) begin
          pc = PW'(hi1_q[k]);
          nc = PW'(lo1_q[k]);
        end else begin
          pc = PW'(lo1_q[k]);
          nc = PW'(hi1_q[k]);
        end
        pp2_d[i][k] = nx * pc;
        pn2_d[i][k] = nx * nc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v_q[0]) begin
      pp2_q <= pp2_d;
      pn2_q <= pn2_d;
    end
  end

  // stage 3: plane distances and signs
  always_comb begin
    logic signed [SW-1:0] dp, dn;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      dp = SW'($signed(plane_q[i][OFFS_LSB +: OFFS_W]));
      dn = dp;
      for (int k = 0; k < AXIS_COUNT; k++) begin
        dp = dp + SW'(pp2_q[i][k]);
        dn = dn + SW'(pn2_q[i][k]);
      end
      pneg3_d[i] = dp[SW-1];
      nneg3_d[i] = dn[SW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v_q[1]) begin
      pneg3_q <= pneg3_d;
      nneg3_q <= nneg3_d;
    end
  end

  // stage 4: classification
  always_comb begin
    if (|pneg3_q) begin
      cls4_d = CLS_OUTSIDE;
    end else if (|nneg3_q) begin
      cls4_d = CLS_INTERSECT;
    end else begin
      cls4_d = CLS_INSIDE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v_q[2]) begin
      cls4_q <= cls4_d;
    end
  end

  assign m_axis_tvalid = v_q[3];
  assign m_axis_tdata  = {(OUT_DATA_W-3)'(0), cls4_q != CLS_OUTSIDE, cls4_q};

  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&v_q) && !m_axis_tready)
    else $error("input stalled with a free stage");

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v_q[0])
    else $error("accepted item not in first stage");

  a_visible_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2] == (m_axis_tdata[1:0] != CLS_OUTSIDE)))
    else $error("visible flag disagrees with classification");

endmodule

/* sim/aabb_frustum_cull_top_test.sv */
// testbench: aabb_frustum_cull_top against a built-in box/plane classifier
`timescale 1ns / 1ps
module aabb_frustum_cull_top_test;
  import afc_pkg::*;

  localparam longint      CHUNK_SPAN       = 16;
  localparam int unsigned PIPE_LATENCY     = 4;
  localparam int unsigned PHASE_COUNT      = 8;
  localparam int unsigned ITEMS_PER_PHASE  = 225;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT      = 400000;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [PLANE_W-1:0]    data;
    logic [CELL_XZ_W-1:0]  x;
    logic [CELL_Y_W-1:0]   y;
    logic [CELL_XZ_W-1:0]  z;
    bit                    typed;
    class_e                cls;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [PLANE_W-1:0]    cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  logic [PLANE_W-1:0]  plane_val [PLANE_COUNT];
  logic [HEIGHT_W-1:0] sect_height;
  class_e              pending_cls [$];
  stim_row_t           dir_rows [$];
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count = 0;
  int unsigned         burst_left = 0;
  bit                  long_hold = 1'b0;

  aabb_frustum_cull_top #(
    .CHUNK_SPAN(16)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [PLANE_W-1:0] pack_plane(logic [NORM_W-1:0] a, logic [NORM_W-1:0] b,
                                                    logic [NORM_W-1:0] c, logic [OFFS_W-1:0] d);
    return {d, c, b, a};
  endfunction

  function automatic class_e classify_section(logic [CELL_XZ_W-1:0] cx, logic [CELL_Y_W-1:0] cy,
                                              logic [CELL_XZ_W-1:0] cz);
    longint lo [AXIS_COUNT];
    longint hi [AXIS_COUNT];
    longint nrm [AXIS_COUNT];
    longint sh;
    longint pv_sum;
    longint nv_sum;
    class_e cls;
    sh = longint'(sect_height);
    lo[0] = CHUNK_SPAN * longint'($signed(cx));
    hi[0] = lo[0] + CHUNK_SPAN;
    lo[1] = sh * longint'($signed(cy));
    hi[1] = lo[1] + sh;
    lo[2] = CHUNK_SPAN * longint'($signed(cz));
    hi[2] = lo[2] + CHUNK_SPAN;
    cls = CLS_INSIDE;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      nrm[0] = longint'($signed(plane_val[p][NORM_W-1:0]));
      nrm[1] = longint'($signed(plane_val[p][2*NORM_W-1:NORM_W]));
      nrm[2] = longint'($signed(plane_val[p][3*NORM_W-1:2*NORM_W]));
      pv_sum = longint'($signed(plane_val[p][PLANE_W-1:OFFS_LSB]));
      nv_sum = pv_sum;
      for (int k = 0; k < AXIS_COUNT; k++) begin
        pv_sum += nrm[k] * ((nrm[k] > 0) ? hi[k] : lo[k]);
        nv_sum += nrm[k] * ((nrm[k] > 0) ? lo[k] : hi[k]);
      end
      if (pv_sum < 0) return CLS_OUTSIDE;
      if (nv_sum < 0) cls = CLS_INTERSECT;
    end
    return cls;
  endfunction

  function automatic stim_row_t cell_row(logic [CELL_XZ_W-1:0] x, logic [CELL_Y_W-1:0] y,
                                         logic [CELL_XZ_W-1:0] z, bit typed = 1'b0,
                                         class_e cls = CLS_INSIDE);
    stim_row_t r;
    r = '{is_cfg: 1'b0, idx: '0, data: '0, x: x, y: y, z: z, typed: typed, cls: cls};
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [PLANE_W-1:0] data);
    stim_row_t r;
    r = '{is_cfg: 1'b1, idx: idx, data: data, x: '0, y: '0, z: '0, typed: 1'b0,
          cls: CLS_INSIDE};
    return r;
  endfunction

  function automatic void add_row(stim_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic logic [NORM_W-1:0] rand_normal();
    case ($urandom_range(7))
      0: return '0;
      1: return NORM_W'($urandom);
      default: return NORM_W'($urandom_range(2048)) - NORM_W'(1024);
    endcase
  endfunction

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_cls.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PLANE_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx < PLANE_COUNT) plane_val[idx] = data;
    else if (idx == REG_SECT_HEIGHT) sect_height = data[HEIGHT_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_cell(logic [CELL_XZ_W-1:0] x, logic [CELL_Y_W-1:0] y,
                           logic [CELL_XZ_W-1:0] z, bit typed, class_e cls);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(5) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_cls.insert(pending_cls.size(), typed ? cls : classify_section(x, y, z));
    burst_left--;
  endtask

  // result checker
  always @(posedge clk_i) begin
    class_e exp_cls;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_cls.size() == 0) begin
        $error("result item with no expectation: tdata %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        exp_cls = pending_cls.pop_front();
        if (m_axis_tdata[1:0] !== exp_cls) begin
          $error("classification: expected %0d, actual %0d", exp_cls, m_axis_tdata[1:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[2] !== (exp_cls != CLS_OUTSIDE)) begin
          $error("visible: expected %0d, actual %0d", exp_cls != CLS_OUTSIDE,
                 m_axis_tdata[2]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stall pattern
  initial begin
    int unsigned tick;
    int unsigned mode;
    tick = 0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
        long_hold = 1'b0;
      end
      if (tick % 64 == 0) mode = $urandom_range(3);
      tick++;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(1);
        2: m_axis_tready <= ($urandom_range(3) == 0);
        default: m_axis_tready <= ($urandom_range(9) != 0);
      endcase
    end
  end

  initial begin
    logic [HEIGHT_W-1:0]  h;
    logic [CELL_XZ_W-1:0] x;
    logic [CELL_Y_W-1:0]  y;
    logic [CELL_XZ_W-1:0] z;
    logic [OFFS_W-1:0]    d;

    for (int i = 0; i < PLANE_COUNT; i++) plane_val[i] = '0;
    sect_height = HEIGHT_RESET;

    // planes all zero after reset: everything inside
    add_row(cell_row(12'h000, 8'h00, 12'h000, 1'b1, CLS_INSIDE));
    add_row(cell_row(12'h7ff, 8'h7f, 12'h7ff, 1'b1, CLS_INSIDE));
    add_row(cell_row(12'h800, 8'hf0, 12'h800, 1'b1, CLS_INSIDE));
    add_row(cell_row(12'hfff, 8'h80, 12'h000, 1'b1, CLS_INSIDE));
    add_row(cell_row(12'h555, 8'haa, 12'haaa, 1'b1, CLS_INSIDE));
    // most negative offset: nothing can reach the plane
    add_row(reg_row(REG_PLANE_LEFT, pack_plane(12'h7ff, '0, '0, 28'h8000000)));
    add_row(cell_row(12'h7ff, 8'h7f, 12'h7ff, 1'b1, CLS_OUTSIDE));
    add_row(cell_row(12'h800, 8'hf0, 12'h800, 1'b1, CLS_OUTSIDE));
    add_row(reg_row(REG_PLANE_LEFT, pack_plane('0, '0, '0, 28'h7ffffff)));
    add_row(cell_row(12'h800, 8'h80, 12'h7ff, 1'b1, CLS_INSIDE));
    // cube 0..64 on each axis
    add_row(reg_row(REG_PLANE_LEFT,   pack_plane(12'd1024, '0, '0, '0)));
    add_row(reg_row(REG_PLANE_RIGHT,  pack_plane(-12'sd1024, '0, '0, 28'd65536)));
    add_row(reg_row(REG_PLANE_BOTTOM, pack_plane('0, 12'd1024, '0, '0)));
    add_row(reg_row(REG_PLANE_TOP,    pack_plane('0, -12'sd1024, '0, 28'd65536)));
    add_row(reg_row(REG_PLANE_NEAR,   pack_plane('0, '0, 12'd1024, '0)));
    add_row(reg_row(REG_PLANE_FAR,    pack_plane('0, '0, -12'sd1024, 28'd65536)));
    add_row(cell_row(12'd0, 8'd0, 12'd0));
    add_row(cell_row(12'hfff, 8'd0, 12'd0));
    add_row(cell_row(12'hffe, 8'd1, 12'd1));
    add_row(cell_row(12'd3, 8'd3, 12'd3));
    add_row(cell_row(12'd4, 8'd1, 12'd1));
    add_row(cell_row(12'd1, 8'd4, 12'd1));
    add_row(reg_row(REG_SECT_HEIGHT, 64'd0));
    add_row(cell_row(12'd1, 8'd5, 12'd1));
    add_row(cell_row(12'd1, 8'hff, 12'd1));
    add_row(reg_row(REG_SECT_HEIGHT, 64'd511));
    add_row(cell_row(12'd1, 8'd0, 12'd1));
    add_row(cell_row(12'd1, 8'hff, 12'd1));
    add_row(reg_row(REG_SECT_HEIGHT, 64'd256));
    add_row(cell_row(12'd0, 8'd0, 12'd0));
    // unused index must leave every register alone
    add_row(reg_row(REG_UNUSED, 64'hffff_ffff_ffff_ffff));
    add_row(cell_row(12'd1, 8'd0, 12'd1));
    add_row(reg_row(REG_SECT_HEIGHT, 64'd1));
    add_row(cell_row(12'd2, 8'd60, 12'd2));
    add_row(cell_row(12'd2, 8'd63, 12'd2));
    add_row(cell_row(12'd2, 8'd64, 12'd2));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_drained();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_cell(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].typed,
                  dir_rows[i].cls);
      end
    end

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_drained();
      case (ph)
        0: h = HEIGHT_RESET;
        1: h = 9'd1;
        2: h = 9'd256;
        3: h = 9'd0;
        4: h = 9'd511;
        default: h = HEIGHT_W'($urandom_range(1, 256));
      endcase
      write_reg(REG_SECT_HEIGHT, PLANE_W'(h));
      for (int i = 0; i < PLANE_COUNT; i++) begin
        if (ph == 5) begin
          write_reg(CFG_IDX_W'(i), {$urandom, $urandom});
        end else begin
          d = OFFS_W'($urandom_range(204800)) - OFFS_W'(20480);
          write_reg(CFG_IDX_W'(i), pack_plane(rand_normal(), rand_normal(), rand_normal(), d));
        end
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 2 && n == 50) long_hold = 1'b1;
        if (ph == 4 && n == 100) wait_drained();
        if ($urandom_range(7) == 0) begin
          x = CELL_XZ_W'($urandom);
          y = CELL_Y_W'($urandom);
          z = CELL_XZ_W'($urandom);
        end else begin
          x = CELL_XZ_W'($urandom_range(15)) - CELL_XZ_W'(8);
          y = CELL_Y_W'($urandom_range(13)) - CELL_Y_W'(4);
          z = CELL_XZ_W'($urandom_range(15)) - CELL_XZ_W'(8);
        end
        send_cell(x, y, z, 1'b0, CLS_INSIDE);
      end
    end

    wait_drained();
    repeat (4 * PIPE_LATENCY) @(posedge clk_i);
    if (mismatch_count == 0 && pending_cls.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* aabb_frustum_cull_top.f */
sv/afc_pkg.sv
sv/aabb_frustum_cull_top.sv
sim/aabb_frustum_cull_top_test.sv
